FILE: rtl/lru_recency_list_defines.svh
// ----------------------------------------------------------------------------
// lru recency list assertion macros
// clocked assertion wrappers used by the lru recency list top file
// ----------------------------------------------------------------------------
`ifndef LRU_RECENCY_LIST_DEFINES_SVH
`define LRU_RECENCY_LIST_DEFINES_SVH
`ifndef ASSERT_OFF
`define LRL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define LRL_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) ante |-> cons) else $error(msg);
`else
`define LRL_ASSERT(label, prop, msg)
`define LRL_ASSERT_IMPL(label, ante, cons, msg)
`endif
`endif

FILE: rtl/lrl_pkg.sv
// ----------------------------------------------------------------------------
// lrl_pkg
// types, codes and field widths shared by the lru recency list modules
// ----------------------------------------------------------------------------
package lrl_pkg;

  localparam int FUNC_W       = 2;
  localparam int FRAME_W      = 6;
  localparam int STATUS_W     = 2;
  localparam int COUNT_W      = 7;
  localparam int MAX_LISTABLE = 2 ** FRAME_W;
  localparam int IN_TDATA_W   = 8;
  localparam int OUT_TDATA_W  = 16;
  localparam int OUT_PAD      = OUT_TDATA_W - STATUS_W - FRAME_W - COUNT_W;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_TOUCH  = 2'd1,
    FUNC_EVICT  = 2'd2
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE   = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_REQERR = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LATCH,
    CMD_INSERT,
    CMD_READ,
    CMD_UNLINK,
    CMD_LINK,
    CMD_EVICT,
    CMD_REPLY
  } cmd_op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_UNLINK,
    S_LINK
  } ctrl_state_t;

  typedef struct packed {
    cmd_op_t op;
    status_t status;
  } dp_cmd_t;

  typedef struct packed {
    func_t func;
    logic  frame_ok;
    logic  is_member;
    logic  is_head;
    logic  empty;
    logic  count_zero;
    logic  out_free;
  } dp_status_t;

endpackage

FILE: rtl/lru_recency_list.sv
// ----------------------------------------------------------------------------
// lru_recency_list
// most-recent-first list of buffer frames with insert, touch and evict
// ----------------------------------------------------------------------------
// One request is handled at a time and gives exactly one result. An insert,
// a touch of the head frame and any rejected request load the result
// register from the decode state; an evict loads it from the unlink state
// and a touch that moves a frame to the head from the link state. A step
// that loads the result waits while an untaken result is held, and the
// request port opens again in the cycle after the result is loaded. The
// steps are set by the prev and next link tables, rams with one write port
// and a registered read: a move reads the links of the frame first, then
// writes each table once to join its neighbors (not for the tail frame) and
// once to link it at the head. The next request is taken while the last
// result still waits in the output register, but its own result is held
// back until the waiting one is taken. No clearing pass is needed after reset.
`include "lru_recency_list_defines.svh"

module lru_recency_list
  import lrl_pkg::*;
#(
  parameter int NUM_FRAMES = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // func[1:0], frame_index[7:2]
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata    // status[1:0], evicted_frame[7:2],
                                            // entry_count[14:8], zero[15]
);

  dp_cmd_t    cmd;
  dp_status_t st;

  lrl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  lrl_datapath #(.NUM_FRAMES(NUM_FRAMES)) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .st       (st)
  );

  `LRL_ASSERT_IMPL(a_one_at_a_time, s_tvalid && s_tready, ##1 !s_tready, "request taken while busy")
  `LRL_ASSERT_IMPL(a_result_follows_work, $rose(m_tvalid), !$past(s_tready), "result without work")
  `LRL_ASSERT(a_empty_count, st.empty == st.count_zero, "empty list and count disagree")

endmodule

FILE: rtl/lrl_ram.sv
// ----------------------------------------------------------------------------
// lrl_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module lrl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/lrl_ctrl.sv
// ----------------------------------------------------------------------------
// lrl_ctrl
// sequencer for one list operation at a time: decode, link reads, link writes
// ----------------------------------------------------------------------------
module lrl_ctrl
  import lrl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  dp_status_t st,
  output dp_cmd_t    cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    cmd.op     = CMD_NONE;
    cmd.status = ST_DONE;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.op     = CMD_LATCH;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (st.func)
          FUNC_INSERT: begin
            if (st.out_free) begin
              state_next = S_IDLE;
              if (st.frame_ok && !st.is_member) begin
                cmd.op = CMD_INSERT;
              end else begin
                cmd.op     = CMD_REPLY;
                cmd.status = ST_REQERR;
              end
            end
          end
          FUNC_TOUCH: begin
            if (st.is_member && !st.is_head) begin
              cmd.op     = CMD_READ;
              state_next = S_UNLINK;
            end else if (st.out_free) begin
              cmd.op     = CMD_REPLY;
              cmd.status = st.is_member ? ST_DONE : ST_REQERR;
              state_next = S_IDLE;
            end
          end
          FUNC_EVICT: begin
            if (!st.empty) begin
              cmd.op     = CMD_READ;
              state_next = S_UNLINK;
            end else if (st.out_free) begin
              cmd.op     = CMD_REPLY;
              cmd.status = ST_EMPTY;
              state_next = S_IDLE;
            end
          end
          default: begin
            if (st.out_free) begin
              cmd.op     = CMD_REPLY;
              cmd.status = ST_REQERR;
              state_next = S_IDLE;
            end
          end
        endcase
      end
      S_UNLINK: begin
        if (st.func == FUNC_EVICT) begin
          // evict writes no links, only moves the tail back or empties the list
          if (st.out_free) begin
            cmd.op     = CMD_EVICT;
            state_next = S_IDLE;
          end
        end else begin
          cmd.op     = CMD_UNLINK;
          state_next = S_LINK;
        end
      end
      S_LINK: begin
        if (st.out_free) begin
          cmd.op     = CMD_LINK;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/lrl_datapath.sv
// ----------------------------------------------------------------------------
// lrl_datapath
// link tables, head, tail, count, member flags and the result register
// ----------------------------------------------------------------------------
module lrl_datapath
  import lrl_pkg::*;
#(
  parameter int NUM_FRAMES = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  input  dp_cmd_t                cmd,
  output dp_status_t             st
);

  localparam int FW  = $clog2(NUM_FRAMES);
  localparam int LW  = FW + 1;
  localparam int MW  = (NUM_FRAMES < MAX_LISTABLE) ? NUM_FRAMES : MAX_LISTABLE;
  localparam int MIW = $clog2(MW);
  localparam int CW  = $clog2(MW + 1);
  localparam logic [LW-1:0] NULL_LINK = '1;

  logic [FUNC_W-1:0]  req_func;
  logic [FRAME_W-1:0] req_frame;
  logic [LW-1:0]      head, head_next, tail, tail_next;
  logic [CW-1:0]      count, count_next;
  logic [MW-1:0]      member, member_next;

  status_t            out_status, load_status;
  logic [FRAME_W-1:0] out_evicted, load_evicted;
  logic [COUNT_W-1:0] out_count;
  logic               load_out;

  logic          nx_we, nx_re, pv_we, pv_re;
  logic [FW-1:0] nx_waddr, pv_waddr, rd_addr;
  logic [LW-1:0] nx_wdata, nx_rdata, pv_wdata, pv_rdata;

  logic [LW-1:0]  req_link;
  logic [MIW-1:0] req_slot, tail_slot;
  logic           frame_ok, empty, is_tail;

  assign req_link  = LW'(req_frame);
  assign req_slot  = req_frame[MIW-1:0];
  assign tail_slot = tail[MIW-1:0];
  assign frame_ok  = (32'(req_frame) < NUM_FRAMES);
  assign empty     = head[LW-1];
  assign is_tail   = (tail == req_link);
  assign rd_addr   = (req_func == FUNC_EVICT) ? tail[FW-1:0] : req_link[FW-1:0];

  assign st.func       = func_t'(req_func);
  assign st.frame_ok   = frame_ok;
  assign st.is_member  = frame_ok && member[req_slot];
  assign st.is_head    = (head == req_link);
  assign st.empty      = empty;
  assign st.count_zero = (count == '0);
  assign st.out_free   = !m_tvalid || m_tready;

  lrl_ram #(.WIDTH(LW), .DEPTH(NUM_FRAMES)) u_next_ram (
    .clk   (clk),
    .we    (nx_we),
    .waddr (nx_waddr),
    .wdata (nx_wdata),
    .re    (nx_re),
    .raddr (rd_addr),
    .rdata (nx_rdata)
  );

  lrl_ram #(.WIDTH(LW), .DEPTH(NUM_FRAMES)) u_prev_ram (
    .clk   (clk),
    .we    (pv_we),
    .waddr (pv_waddr),
    .wdata (pv_wdata),
    .re    (pv_re),
    .raddr (rd_addr),
    .rdata (pv_rdata)
  );

  // prev of the head and next of the tail are never kept up to date
  always_comb begin
    head_next    = head;
    tail_next    = tail;
    count_next   = count;
    member_next  = member;
    nx_we        = 1'b0;
    nx_re        = 1'b0;
    nx_waddr     = req_link[FW-1:0];
    nx_wdata     = head;
    pv_we        = 1'b0;
    pv_re        = 1'b0;
    pv_waddr     = head[FW-1:0];
    pv_wdata     = req_link;
    load_out     = 1'b0;
    load_status  = ST_DONE;
    load_evicted = '0;
    case (cmd.op)
      CMD_INSERT: begin
        nx_we     = 1'b1;
        pv_we     = !empty;
        head_next = req_link;
        if (empty) begin
          tail_next = req_link;
        end
        member_next[req_slot] = 1'b1;
        count_next = count + 1'b1;
        load_out   = 1'b1;
      end
      CMD_READ: begin
        nx_re = 1'b1;
        pv_re = 1'b1;
      end
      CMD_UNLINK: begin
        // join the neighbors of the moved frame
        if (!is_tail) begin
          nx_we    = 1'b1;
          nx_waddr = pv_rdata[FW-1:0];
          nx_wdata = nx_rdata;
          pv_we    = 1'b1;
          pv_waddr = nx_rdata[FW-1:0];
          pv_wdata = pv_rdata;
        end
      end
      CMD_LINK: begin
        nx_we     = 1'b1;
        pv_we     = 1'b1;
        head_next = req_link;
        if (is_tail) begin
          tail_next = pv_rdata;
        end
        load_out = 1'b1;
      end
      CMD_EVICT: begin
        if (head == tail) begin
          head_next = NULL_LINK;
          tail_next = NULL_LINK;
        end else begin
          tail_next = pv_rdata;
        end
        member_next[tail_slot] = 1'b0;
        count_next   = count - 1'b1;
        load_evicted = FRAME_W'(tail);
        load_out     = 1'b1;
      end
      CMD_REPLY: begin
        load_status = cmd.status;
        load_out    = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head   <= NULL_LINK;
      tail   <= NULL_LINK;
      count  <= '0;
      member <= '0;
    end else begin
      head   <= head_next;
      tail   <= tail_next;
      count  <= count_next;
      member <= member_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == CMD_LATCH) begin
      req_func  <= s_tdata[FUNC_W-1:0];
      req_frame <= s_tdata[FUNC_W +: FRAME_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status  <= load_status;
      out_evicted <= load_evicted;
      out_count   <= COUNT_W'(count_next);
    end
  end

  assign m_tdata = {{OUT_PAD{1'b0}}, out_count, out_evicted, out_status};

endmodule
